// File: hw/rtl/decimating_dc_blocker_core_defines.svh
// Assertion helpers shared by the DC blocker RTL.
// Each expects aclk and aresetn in the enclosing scope.
`ifndef DECIMATING_DC_BLOCKER_CORE_DEFINES_SVH
`define DECIMATING_DC_BLOCKER_CORE_DEFINES_SVH

// Property that must hold at every edge out of reset
`define DDCB_ASSERT_NOW(name, expr, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Property that must hold in the cycle after the antecedent
`define DDCB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ddcb_pkg.sv
`timescale 1ns / 1ps

package ddcb_pkg;

    // Field and state widths
    localparam int SAMPLE_W = 16;
    localparam int DEC_W    = 7;
    localparam int SHIFT_W  = 4;
    localparam int COUNT_W  = 6;
    localparam int SUM_W    = 22;
    localparam int ACC_W    = 32;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = DEC_W;
    localparam logic [CFG_INDEX_W-1:0] REG_DECIMATION = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SHIFT_BITS = 1'd1;

    // Register reset values and decimation limits
    localparam logic [DEC_W-1:0]   DEC_RESET   = 7'd8;
    localparam logic [DEC_W-1:0]   DEC_MIN     = 7'd1;
    localparam logic [DEC_W-1:0]   DEC_MAX     = 7'd64;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd0;

    // Filter coefficient 0.995 in Q0.16, kept positive with a spare sign bit
    localparam int               COEF_W   = 17;
    localparam logic [COEF_W-1:0] COEF_Q16 = 17'd65208;
    localparam int               COEF_FRAC = 16;
    localparam int               PROD_W    = ACC_W + COEF_W;

    // Saturation limits
    localparam logic [SAMPLE_W-1:0] SAT_POS = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAT_NEG = 16'h8000;

    // Queue between grouping and filter
    localparam int DEF_QUEUE_DEPTH = 2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    group_x_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

endpackage

// File: hw/rtl/decimating_dc_blocker_core.sv
// Decimating DC blocker: sums groups of samples, shifts, then high-pass filters.
// A group-ending beat goes into the queue, then the output register behind m_valid.
// Throughput: one input beat per cycle unless a group-ending beat finds the queue
// full; one result per group, from a combinational multiply, add, saturate loop.
// Reset (synchronous, aresetn low): sums, counts, filter state and queue clear,
// decimation returns to 8 and shift_bits to 0; ready again the next cycle.
`timescale 1ns / 1ps

module decimating_dc_blocker_core #(
    parameter int QUEUE_DEPTH = ddcb_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ddcb_pkg::sample_t                   s_sample_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ddcb_pkg::sample_t                   m_sample_out,
    output logic                                m_clipped,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ddcb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ddcb_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ddcb_pkg::*;

    logic     fq_valid, fq_ready;
    group_x_t fq_x;
    logic     qb_valid, qb_ready;
    group_x_t qb_x;

    // Grouping and shift
    ddcb_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample_in (s_sample_in),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_valid     (fq_valid),
        .q_x         (fq_x),
        .q_ready     (fq_ready)
    );

    // Decoupling queue
    ddcb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_x      (fq_x),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_x     (qb_x)
    );

    // DC-blocking filter and output register
    ddcb_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (qb_valid),
        .q_ready      (qb_ready),
        .q_x          (qb_x),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_clipped    (m_clipped)
    );

endmodule

// File: hw/rtl/ddcb_front.sv
`timescale 1ns / 1ps
`include "decimating_dc_blocker_core_defines.svh"

module ddcb_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ddcb_pkg::sample_t                   s_sample_in,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ddcb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ddcb_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                q_valid,
    output ddcb_pkg::group_x_t                  q_x,
    input  logic                                q_ready
);
    import ddcb_pkg::*;

    logic [DEC_W-1:0]   dec_reg, dec_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    group_x_t           group_sum_reg, group_sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic [DEC_W-1:0]   dec_eff;
    logic [DEC_W-1:0]   count_inc;
    logic               group_end;
    logic               accept;
    group_x_t           sum_total;

    // Clamp decimation into 1..64
    always_comb begin
        if (dec_reg == '0) begin
            dec_eff = DEC_MIN;
        end else if (dec_reg > DEC_MAX) begin
            dec_eff = DEC_MAX;
        end else begin
            dec_eff = dec_reg;
        end
    end

    // Group completes when this beat brings the count up to the decimation
    assign count_inc = {1'b0, count_reg} + DEC_W'(1);
    assign group_end = (count_inc >= dec_eff);

    // Only a group-ending beat needs room in the queue
    assign s_ready   = !group_end || q_ready;
    assign accept    = s_valid && s_ready;
    assign sum_total = group_sum_reg + group_x_t'(s_sample_in);

    assign q_valid   = s_valid && group_end;
    assign q_x       = sum_total >>> shift_reg;

    assign cfg_ready = 1'b1;

    // Accumulator and counter
    always_comb begin
        group_sum_next = group_sum_reg;
        count_next     = count_reg;
        if (accept) begin
            if (group_end) begin
                group_sum_next = '0;
                count_next     = '0;
            end else begin
                group_sum_next = sum_total;
                count_next     = count_inc[COUNT_W-1:0];
            end
        end
    end

    // Register writes
    always_comb begin
        dec_next   = dec_reg;
        shift_next = shift_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_DECIMATION: begin
                    dec_next = cfg_data;
                end
                REG_SHIFT_BITS: begin
                    shift_next = cfg_data[SHIFT_W-1:0];
                end
                default: begin
                    dec_next = dec_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_reg       <= DEC_RESET;
            shift_reg     <= SHIFT_RESET;
            group_sum_reg <= '0;
            count_reg     <= '0;
        end else begin
            dec_reg       <= dec_next;
            shift_reg     <= shift_next;
            group_sum_reg <= group_sum_next;
            count_reg     <= count_next;
        end
    end

    `DDCB_ASSERT_NEXT(a_group_restarts, accept && group_end, (count_reg == '0) && (group_sum_reg == '0), "group state not cleared after group end")

endmodule

// File: hw/rtl/ddcb_queue.sv
`timescale 1ns / 1ps
`include "decimating_dc_blocker_core_defines.svh"

module ddcb_queue #(
    parameter int DEPTH = ddcb_pkg::DEF_QUEUE_DEPTH  // 2 or more
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  ddcb_pkg::group_x_t  in_x,
    output logic                out_valid,
    input  logic                out_ready,
    output ddcb_pkg::group_x_t  out_x
);
    import ddcb_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    group_x_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_x     = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_x;
        end
    end

    `DDCB_ASSERT_NOW(a_fill_bound, count_reg <= CNT_W'(DEPTH), "queue fill above depth")
    `DDCB_ASSERT_NEXT(a_fill_grows, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue fill did not grow on push")

endmodule

// File: hw/rtl/ddcb_back.sv
`timescale 1ns / 1ps
`include "decimating_dc_blocker_core_defines.svh"

module ddcb_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  ddcb_pkg::group_x_t  q_x,
    output logic                m_valid,
    input  logic                m_ready,
    output ddcb_pkg::sample_t   m_sample_out,
    output logic                m_clipped
);
    import ddcb_pkg::*;

    group_x_t                last_input_reg, last_input_next;
    acc_t                    last_output_reg, last_output_next;
    logic                    m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0]     sample_out_reg, sample_out_next;
    logic                    clipped_reg, clipped_next;

    logic                    take;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_adj;
    acc_t                    scaled;
    acc_t                    y_val;
    logic                    clip;

    // Output register frees up when empty or being drained this cycle
    assign q_ready = !m_valid_reg || m_ready;
    assign take    = q_valid && q_ready;

    // 0.995 * y_prev, truncated toward zero
    assign prod     = $signed(last_output_reg) * $signed(COEF_Q16);
    assign prod_adj = prod + $signed({{(PROD_W - COEF_FRAC){1'b0}}, {COEF_FRAC{prod[PROD_W-1]}}});
    assign scaled   = prod_adj[COEF_FRAC +: ACC_W];

    // y = x - x_prev + a*y_prev, wrapping at 32 bits
    assign y_val = acc_t'(q_x) - acc_t'(last_input_reg) + scaled;
    assign clip  = !((&y_val[ACC_W-1:SAMPLE_W-1]) || !(|y_val[ACC_W-1:SAMPLE_W-1]));

    always_comb begin
        last_input_next  = last_input_reg;
        last_output_next = last_output_reg;
        sample_out_next  = sample_out_reg;
        clipped_next     = clipped_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        if (take) begin
            last_input_next  = q_x;
            last_output_next = y_val;
            clipped_next     = clip;
            m_valid_next     = 1'b1;
            if (clip) begin
                sample_out_next = y_val[ACC_W-1] ? SAT_NEG : SAT_POS;
            end else begin
                sample_out_next = y_val[SAMPLE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_input_reg  <= '0;
            last_output_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            last_input_reg  <= last_input_next;
            last_output_reg <= last_output_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        sample_out_reg <= sample_out_next;
        clipped_reg    <= clipped_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = sample_out_reg;
    assign m_clipped    = clipped_reg;

    `DDCB_ASSERT_NEXT(a_take_gives_beat, take, m_valid_reg && (last_input_reg == $past(q_x)), "taken group did not reach the output register")

endmodule
